FILE: sv/bfs_pkg.sv
// Shared types and constants of the breadth-first route block.
package bfs_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_ROUTE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
    localparam logic [1:0] STATUS_RANGE       = 2'd2;
    localparam logic [1:0] STATUS_FULL        = 2'd3;

    localparam logic [6:0] UNREACHED = 7'd127;
    localparam logic [6:0] LEVEL_CAP = 7'd126;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ADD  = 14'b00000000000010,
        S_RESP = 14'b00000000000100,
        S_LVL  = 14'b00000000001000,
        S_VRD  = 14'b00000000010000,
        S_VCHK = 14'b00000000100000,
        S_NCNT = 14'b00000001000000,
        S_NRD  = 14'b00000010000000,
        S_WRD  = 14'b00000100000000,
        S_WCHK = 14'b00001000000000,
        S_DONE = 14'b00010000000000,
        S_DCHK = 14'b00100000000000,
        S_WALK = 14'b01000000000000,
        S_PRED = 14'b10000000000000
    } state_t;

endpackage

FILE: sv/bfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/bfs_shortest_route.sv
// Top level of the breadth-first shortest route block over a stored adjacency map.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_ready   | mode, vertex_a, vertex_b
//   output  | out       | out_valid / out_ready | route_vertex, last, status
//   config  | in        | cfg_we                | cfg_wdata (vertex count)
//
// Clear and add beats pass through S_RESP (add also through S_ADD); a route query
// scans every vertex of each level and its neighbours through the single read
// port of the level memory, then walks the predecessors back and emits the route.
// One item is worked on at a time; a result waits in the output register.
// Reset empties the map and sets the vertex count to 64; no clearing pass.
module bfs_shortest_route
    import bfs_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [5:0] vertex_a,
    input  logic [5:0] vertex_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] route_vertex,
    output logic       last,
    output logic [1:0] status,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int CAP = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;

    state_t state_reg, state_next;
    logic [5:0] a_reg, a_next, b_reg, b_next;
    logic [6:0] vc_reg, vc_next;
    logic [6:0] lvl_reg, lvl_next, v_reg, v_next;
    logic       any_reg, any_next;
    logic [CW-1:0] n_reg, n_next, d_reg, d_next;
    logic [5:0] w_reg, w_next, cur_reg, cur_next;
    logic [6:0] len_reg, len_next, i_reg, i_next;
    logic [1:0] res_reg, res_next;
    logic       emit_reg, emit_next;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] out_vertex_reg, out_vertex_next;
    logic       out_last_reg, out_last_next;
    logic [1:0] out_status_reg, out_status_next;
    logic [MAX_VERTICES-1:0] lv_valid_reg, lv_valid_next;
    logic [MAX_VERTICES-1:0] nc_valid_reg, nc_valid_next;
    logic       lv_hit_reg, lv_hit_next, nc_hit_reg, nc_hit_next;

    logic [6:0] cnt;
    logic       out_free;

    logic            lv_we, lv_re;
    logic [AW-1:0]   lv_waddr, lv_raddr;
    logic [12:0]     lv_wdata, lv_rdata;
    logic            nc_we, nc_re;
    logic [AW-1:0]   nc_waddr, nc_raddr;
    logic [CW-1:0]   nc_wdata, nc_rdata;
    logic            nt_we, nt_re;
    logic [NAW-1:0]  nt_waddr, nt_raddr;
    logic [5:0]      nt_wdata, nt_rdata;
    logic            rb_we, rb_re;
    logic [5:0]      rb_waddr, rb_raddr, rb_wdata, rb_rdata;

    logic [6:0] lv_level;
    logic [5:0] lv_pred;
    logic [CW-1:0] nc_val;

    bfs_ram #(.WIDTH(13), .DEPTH(MAX_VERTICES)) u_level (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
        .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata)
    );

    bfs_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_count (
        .clk(clk), .we(nc_we), .waddr(nc_waddr), .wdata(nc_wdata),
        .re(nc_re), .raddr(nc_raddr), .rdata(nc_rdata)
    );

    bfs_ram #(.WIDTH(6), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_neighbor (
        .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
        .re(nt_re), .raddr(nt_raddr), .rdata(nt_rdata)
    );

    bfs_ram #(.WIDTH(6), .DEPTH(64)) u_route (
        .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
        .re(rb_re), .raddr(rb_raddr), .rdata(rb_rdata)
    );

    assign cnt      = (int'(vc_reg) > CAP) ? 7'(CAP) : vc_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign lv_level = lv_hit_reg ? lv_rdata[12:6] : UNREACHED;
    assign lv_pred  = lv_hit_reg ? lv_rdata[5:0] : 6'd0;
    assign nc_val   = nc_hit_reg ? nc_rdata : '0;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign route_vertex = out_vertex_reg;
    assign last         = out_last_reg;
    assign status       = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        vc_next         = cfg_we ? cfg_wdata : vc_reg;
        lvl_next        = lvl_reg;
        v_next          = v_reg;
        any_next        = any_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        w_next          = w_reg;
        cur_next        = cur_reg;
        len_next        = len_reg;
        i_next          = i_reg;
        res_next        = res_reg;
        emit_next       = emit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        lv_valid_next   = lv_valid_reg;
        nc_valid_next   = nc_valid_reg;
        lv_hit_next     = lv_hit_reg;
        nc_hit_next     = nc_hit_reg;

        lv_we = 1'b0; lv_re = 1'b0; lv_waddr = '0; lv_raddr = '0; lv_wdata = '0;
        nc_we = 1'b0; nc_re = 1'b0; nc_waddr = '0; nc_raddr = '0; nc_wdata = '0;
        nt_we = 1'b0; nt_re = 1'b0; nt_waddr = '0; nt_raddr = '0; nt_wdata = '0;
        rb_we = 1'b0; rb_re = 1'b0; rb_waddr = '0; rb_raddr = '0; rb_wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next    = vertex_a;
                    b_next    = vertex_b;
                    if (mode == MODE_CLEAR)
                    begin
                        nc_valid_next = '0;
                        res_next      = STATUS_OK;
                        state_next    = S_RESP;
                    end
                    else if (mode == MODE_ADD || mode == MODE_ROUTE)
                    begin
                        if ({1'b0, vertex_a} >= cnt || {1'b0, vertex_b} >= cnt)
                        begin
                            res_next   = STATUS_RANGE;
                            state_next = S_RESP;
                        end
                        else if (mode == MODE_ADD)
                        begin
                            nc_re       = 1'b1;
                            nc_raddr    = AW'(vertex_a);
                            nc_hit_next = nc_valid_reg[AW'(vertex_a)];
                            state_next  = S_ADD;
                        end
                        else
                        begin
                            lv_valid_next                 = '0;
                            lv_valid_next[AW'(vertex_a)]  = 1'b1;
                            lv_we      = 1'b1;
                            lv_waddr   = AW'(vertex_a);
                            lv_wdata   = 13'd0;
                            lvl_next   = 7'd0;
                            state_next = S_LVL;
                        end
                    end
                end
            end
            S_ADD:
            begin
                if (int'(nc_val) >= MAX_DEGREE)
                begin
                    res_next = STATUS_FULL;
                end
                else
                begin
                    nt_we    = 1'b1;
                    nt_waddr = NAW'(int'(a_reg) * MAX_DEGREE + int'(nc_val));
                    nt_wdata = b_reg;
                    nc_we    = 1'b1;
                    nc_waddr = AW'(a_reg);
                    nc_wdata = CW'(nc_val + 1'b1);
                    nc_valid_next[AW'(a_reg)] = 1'b1;
                    res_next = STATUS_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = 6'd0;
                    out_last_next   = 1'b1;
                    out_status_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            S_LVL:
            begin
                if (lvl_reg < cnt && lvl_reg < LEVEL_CAP)
                begin
                    v_next     = 7'd0;
                    any_next   = 1'b0;
                    state_next = S_VRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_VRD:
            begin
                if (v_reg < cnt)
                begin
                    lv_re       = 1'b1;
                    lv_raddr    = AW'(v_reg);
                    lv_hit_next = lv_valid_reg[AW'(v_reg)];
                    state_next  = S_VCHK;
                end
                else if (any_reg)
                begin
                    lvl_next   = lvl_reg + 7'd1;
                    state_next = S_LVL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_VCHK:
            begin
                if (lv_level == lvl_reg)
                begin
                    any_next    = 1'b1;
                    nc_re       = 1'b1;
                    nc_raddr    = AW'(v_reg);
                    nc_hit_next = nc_valid_reg[AW'(v_reg)];
                    state_next  = S_NCNT;
                end
                else
                begin
                    v_next     = v_reg + 7'd1;
                    state_next = S_VRD;
                end
            end
            S_NCNT:
            begin
                n_next     = nc_val;
                d_next     = '0;
                state_next = S_NRD;
            end
            S_NRD:
            begin
                if (d_reg < n_reg)
                begin
                    nt_re      = 1'b1;
                    nt_raddr   = NAW'(int'(v_reg) * MAX_DEGREE + int'(d_reg));
                    state_next = S_WRD;
                end
                else
                begin
                    v_next     = v_reg + 7'd1;
                    state_next = S_VRD;
                end
            end
            S_WRD:
            begin
                w_next = nt_rdata;
                d_next = d_reg + 1'b1;
                if ({1'b0, nt_rdata} < cnt)
                begin
                    lv_re       = 1'b1;
                    lv_raddr    = AW'(nt_rdata);
                    lv_hit_next = lv_valid_reg[AW'(nt_rdata)];
                    state_next  = S_WCHK;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end
            S_WCHK:
            begin
                if (lv_level == UNREACHED)
                begin
                    lv_we    = 1'b1;
                    lv_waddr = AW'(w_reg);
                    lv_wdata = {7'(lvl_reg + 7'd1), v_reg[5:0]};
                    lv_valid_next[AW'(w_reg)] = 1'b1;
                end
                state_next = S_NRD;
            end
            S_DONE:
            begin
                lv_re       = 1'b1;
                lv_raddr    = AW'(b_reg);
                lv_hit_next = lv_valid_reg[AW'(b_reg)];
                emit_next   = 1'b0;
                state_next  = S_DCHK;
            end
            S_DCHK:
            begin
                if (lv_level == UNREACHED)
                begin
                    res_next   = STATUS_UNREACHABLE;
                    state_next = S_RESP;
                end
                else
                begin
                    len_next   = lv_level + 7'd1;
                    i_next     = lv_level + 7'd1;
                    cur_next   = b_reg;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                rb_we       = 1'b1;
                rb_waddr    = 6'(i_reg - 7'd1);
                rb_wdata    = cur_reg;
                lv_re       = 1'b1;
                lv_raddr    = AW'(cur_reg);
                lv_hit_next = lv_valid_reg[AW'(cur_reg)];
                i_next      = i_reg - 7'd1;
                state_next  = S_PRED;
            end
            S_PRED:
            begin
                if (!emit_reg)
                begin
                    cur_next = ({1'b0, lv_pred} >= cnt) ? 6'd0 : lv_pred;
                    if (i_reg == 7'd0)
                    begin
                        emit_next = 1'b1;
                        rb_re     = 1'b1;
                        rb_raddr  = 6'd0;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
                else if (out_free)
                begin
                    // The route buffer read data holds until the next read is issued.
                    out_valid_next  = 1'b1;
                    out_vertex_next = rb_rdata;
                    out_last_next   = (7'(i_reg + 7'd1) == len_reg);
                    out_status_next = STATUS_OK;
                    i_next          = i_reg + 7'd1;
                    if (7'(i_reg + 7'd1) == len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rb_re    = 1'b1;
                        rb_raddr = 6'(i_reg + 7'd1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vc_reg        <= 7'd64;
            out_valid_reg <= 1'b0;
            lv_valid_reg  <= '0;
            nc_valid_reg  <= '0;
            lv_hit_reg    <= 1'b0;
            nc_hit_reg    <= 1'b0;
            emit_reg      <= 1'b0;
            lvl_reg       <= '0;
            v_reg         <= '0;
            any_reg       <= 1'b0;
            n_reg         <= '0;
            d_reg         <= '0;
            i_reg         <= '0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
            lv_valid_reg  <= lv_valid_next;
            nc_valid_reg  <= nc_valid_next;
            lv_hit_reg    <= lv_hit_next;
            nc_hit_reg    <= nc_hit_next;
            emit_reg      <= emit_next;
            lvl_reg       <= lvl_next;
            v_reg         <= v_next;
            any_reg       <= any_next;
            n_reg         <= n_next;
            d_reg         <= d_next;
            i_reg         <= i_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        w_reg          <= w_next;
        cur_reg        <= cur_next;
        res_reg        <= res_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

endmodule
